// File: sv/srfw_pkg.sv
`default_nettype none
package srfw_pkg;

    localparam int CAPACITY     = 4096;
    localparam int AW           = $clog2(CAPACITY);  // store address
    localparam int PW           = AW + 1;            // pointers count mod 2*CAPACITY
    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = 4;
    localparam int FRAMES_W     = 13;
    localparam int CNT_W        = FRAMES_W + CH_W;   // samples per block
    localparam int SUM_W        = CNT_W + 1;
    localparam int SAMPLE_W     = 32;
    localparam int PCT_W        = 7;
    localparam int PCT_MUL      = 100;
    localparam int PROD_W       = AW + PCT_W;
    localparam int OCC_W        = 12;
    localparam int CNTR_W       = 32;
    localparam int IN_DATA_W    = 48;
    localparam int IN_USER_W    = 2;
    localparam int OUT_DATA_W   = 128;
    localparam int OUT_PAD_W    = OUT_DATA_W - (SAMPLE_W + 1 + 2 * PCT_W + OCC_W + 2 * CNTR_W);

    localparam logic [CH_W-1:0] CH_RESET = CH_W'(2);

    // item kinds carried in tuser[0]
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // controller -> datapath strobes
    typedef struct packed {
        logic latch;   // capture the accepted item
        logic decide;  // block decision, pointer move, store access
        logic finish;  // watermarks, load result register
    } t_dp_cmd;

endpackage
`default_nettype wire

// File: sv/srfw_ctrl.sv
`default_nettype none
module srfw_ctrl
    import srfw_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DEC  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid & ~i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                // result register must be free or drained this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: sv/srfw_dpath.sv
`default_nettype none
module srfw_dpath
    import srfw_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  wire [CH_W-1:0]         i_channels,
    input  wire                    i_item_cmd,
    input  wire                    i_item_first,
    input  wire [FRAMES_W-1:0]     i_frames,
    input  wire [SAMPLE_W-1:0]     i_sample,
    output logic [OUT_DATA_W-1:0]  o_result
);

    logic [SAMPLE_W-1:0] r_mem [CAPACITY];

    // captured item
    logic                r_cmd;
    logic                r_first;
    logic [CNT_W-1:0]    r_count;
    logic [SAMPLE_W-1:0] r_sample;

    // block state
    logic [PW-1:0]       r_wp, n_wp;
    logic [PW-1:0]       r_rp, n_rp;
    logic                r_wacc, n_wacc;
    logic                r_rserved, n_rserved;
    logic [CNT_W-1:0]    r_wleft, n_wleft;
    logic [CNT_W-1:0]    r_rleft, n_rleft;
    logic [OCC_W-1:0]    r_occ_rec, n_occ_rec;
    logic                r_rec, n_rec;
    logic [CNTR_W-1:0]   r_ovr, n_ovr;
    logic [CNTR_W-1:0]   r_und, n_und;
    logic                r_ok, n_ok;
    logic                r_rd_en, n_rd_en;
    logic [PCT_W-1:0]    r_usage, n_usage;
    logic [PCT_W-1:0]    r_peak, n_peak;
    logic [SAMPLE_W-1:0] r_ram_q;
    logic [OUT_DATA_W-1:0] r_result;

    logic                we, re;
    logic [PW-1:0]       occ;
    logic [SUM_W-1:0]    sum;
    logic [CH_W-1:0]     ch_eff;
    logic [PROD_W-1:0]   prod;
    logic [PCT_W-1:0]    pct;

    assign ch_eff = (i_channels > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : i_channels;

    // block decision and data move
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_wacc    = r_wacc;
        n_rserved = r_rserved;
        n_wleft   = r_wleft;
        n_rleft   = r_rleft;
        n_occ_rec = r_occ_rec;
        n_rec     = 1'b0;
        n_ovr     = r_ovr;
        n_und     = r_und;
        n_ok      = 1'b0;
        n_rd_en   = 1'b0;
        we        = 1'b0;
        re        = 1'b0;
        occ       = r_wp - r_rp;
        sum       = SUM_W'(occ) + SUM_W'(r_count);

        if (r_first) begin
            if (r_cmd == CMD_WRITE) begin
                if (occ[PW-1] || (sum > SUM_W'(CAPACITY - 1))) begin
                    n_ovr   = r_ovr + CNTR_W'(1);
                    n_wacc  = 1'b0;
                    n_wleft = '0;
                end else begin
                    n_wacc    = 1'b1;
                    n_wleft   = r_count;
                    n_occ_rec = sum[OCC_W-1:0];
                    n_rec     = 1'b1;
                end
            end else begin
                n_rleft = r_count;
                n_rec   = 1'b1;
                if (CNT_W'(occ) < r_count) begin
                    n_und     = r_und + CNTR_W'(1);
                    n_rserved = 1'b0;
                    n_occ_rec = occ[OCC_W-1:0];
                end else begin
                    n_rserved = 1'b1;
                    n_occ_rec = OCC_W'(CNT_W'(occ) - r_count);
                end
            end
        end

        if (r_cmd == CMD_WRITE) begin
            if (n_wacc && (n_wleft != '0)) begin
                we      = 1'b1;
                n_wp    = r_wp + PW'(1);
                n_wleft = n_wleft - CNT_W'(1);
            end
            n_ok = n_wacc;
        end else begin
            if (n_rleft != '0) begin
                if (n_rserved) begin
                    re   = 1'b1;
                    n_rp = r_rp + PW'(1);
                end
                n_rleft = n_rleft - CNT_W'(1);
            end
            n_rd_en = re;
            n_ok    = n_rserved;
        end

        we = we & i_cmd.decide;
        re = re & i_cmd.decide;
    end

    // watermarks from the occupancy recorded at block start
    always_comb begin
        prod    = PROD_W'(r_occ_rec) * PROD_W'(PCT_MUL);
        pct     = PCT_W'(prod >> AW);
        n_usage = r_rec ? pct : r_usage;
        n_peak  = (r_rec && (pct > r_peak)) ? pct : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_wp[AW-1:0]] <= r_sample;
        end
        if (re) begin
            r_ram_q <= r_mem[r_rp[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd    <= i_item_cmd;
            r_first  <= i_item_first;
            r_sample <= i_sample;
            r_count  <= CNT_W'(i_frames) * CNT_W'(ch_eff);
        end
        if (i_cmd.decide) begin
            r_ok    <= n_ok;
            r_rd_en <= n_rd_en;
        end
        if (i_cmd.finish) begin
            r_result <= {{OUT_PAD_W{1'b0}}, r_und, r_ovr, r_occ_rec, n_peak, n_usage, r_ok,
                         (r_rd_en ? r_ram_q : {SAMPLE_W{1'b0}})};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_wacc    <= 1'b0;
            r_rserved <= 1'b0;
            r_wleft   <= '0;
            r_rleft   <= '0;
            r_occ_rec <= '0;
            r_rec     <= 1'b0;
            r_ovr     <= '0;
            r_und     <= '0;
            r_usage   <= '0;
            r_peak    <= '0;
        end else begin
            if (i_cmd.decide) begin
                r_wp      <= n_wp;
                r_rp      <= n_rp;
                r_wacc    <= n_wacc;
                r_rserved <= n_rserved;
                r_wleft   <= n_wleft;
                r_rleft   <= n_rleft;
                r_occ_rec <= n_occ_rec;
                r_rec     <= n_rec;
                r_ovr     <= n_ovr;
                r_und     <= n_und;
            end
            if (i_cmd.finish) begin
                r_usage <= n_usage;
                r_peak  <= n_peak;
                r_rec   <= 1'b0;
            end
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

// File: sv/sample_ring_fifo_with_watermark_core.sv
// Result: the captured item goes through decide, then finish loads the result register;
//   finish waits while the previous result is still held. A new item is taken only
//   after finish (capture, decide with one store access, finish).
// Reset: synchronous, active low; clears pointers, block flags, counters and
//   watermarks, sets channels to 2. The sample store is not cleared.
`default_nettype none
module sample_ring_fifo_with_watermark_core
    import srfw_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // input stream
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [IN_DATA_W-1:0]    i_s_axis_tdata,   // [12:0] block_frames, [44:13] sample
    input  wire [IN_USER_W-1:0]    i_s_axis_tuser,   // [0] cmd, [1] first
    // result stream
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // [31:0] read_data, [32] block_ok, [39:33] fill_pct, [46:40] peak_percent,
    // [58:47] fill_words, [90:59] drop_blocks, [122:91] starve_blocks
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    // configuration port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [2:0]              paddr,
    input  wire [31:0]             pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_dp_cmd          dp_cmd;
    logic [CH_W-1:0]  r_channels;
    logic             cfg_sel;

    // one register (channels) at byte address 0; paddr[2] picks beyond the list
    assign cfg_sel = ~paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels <= CH_RESET;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_channels <= pwdata[CH_W-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(32 - CH_W){1'b0}}, r_channels} : 32'd0;

    // sequencer: capture -> decide -> finish
    srfw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (dp_cmd)
    );

    // pointers, store, counters and the result register
    srfw_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_channels   (r_channels),
        .i_item_cmd   (i_s_axis_tuser[0]),
        .i_item_first (i_s_axis_tuser[1]),
        .i_frames     (i_s_axis_tdata[FRAMES_W-1:0]),
        .i_sample     (i_s_axis_tdata[FRAMES_W +: SAMPLE_W]),
        .o_result     (o_m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: sv/srfw_chk.sv
`default_nettype none
module srfw_chk
    import srfw_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_axis_tvalid,
    input wire                   o_s_axis_tready,
    input wire                   o_m_axis_tvalid,
    input wire                   i_m_axis_tready,
    input wire [OUT_DATA_W-1:0]  o_m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight: no transfer right after a transfer
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while busy");

    // peak watermark never below current usage
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[46:40] >= o_m_axis_tdata[39:33])
        else $error("peak below usage");

    // failed or unserved block gives no sample
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[32] |-> o_m_axis_tdata[31:0] == 32'd0)
        else $error("data on failed block");

endmodule

bind sample_ring_fifo_with_watermark_core srfw_chk u_srfw_chk (.*);
`default_nettype wire
